### hdl/neighbour_mean_filter_3x3_unit_macros.svh
// Assertion macros shared by the neighbor mean filter modules.
`ifndef NEIGHBOUR_MEAN_FILTER_3X3_UNIT_MACROS_SVH
`define NEIGHBOUR_MEAN_FILTER_3X3_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define NMF_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define NMF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/nmf_pkg.sv
// Shared constants, state type and control structs of the neighbor mean filter.
package nmf_pkg;

  localparam int MAX_SIZE_DEF   = 64;
  localparam int VALUE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int             CFG_W      = 7;
  localparam logic [CFG_W-1:0] SIZE_RESET = 7'd8;

  localparam int POS_OUT_W  = 6;
  localparam int MEAN_W     = 24;
  localparam int COUNT_W    = 4;
  localparam int OUT_DATA_W = 2 * POS_OUT_W + MEAN_W + COUNT_W;

  // A sum of eight values needs three bits more than one value.
  localparam int SUM_GROW  = 3;
  // Dividend bits fed to the reciprocal multiplier in one cycle.
  localparam int DIV_STEPS = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } nmf_state_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic sum;
    logic div_step;
    logic emit;
    logic advance;
    logic sel_row;
    logic sel_col;
  } nmf_cmd_t;

  typedef struct packed {
    logic has_results;
    logic last_row;
    logic last_col;
    logic out_free;
  } nmf_sts_t;

endpackage

### hdl/nmf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module nmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/nmf_datapath.sv
// Datapath: line store, 3x3 window, neighbor sum, reciprocal divider and output register.
`include "neighbour_mean_filter_3x3_unit_macros.svh"
module nmf_datapath #(
  parameter int MAX_SIZE   = nmf_pkg::MAX_SIZE_DEF,
  parameter int VALUE_BITS = nmf_pkg::VALUE_BITS_DEF,
  parameter int FRAC_BITS  = nmf_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [VALUE_BITS-1:0]      in_value,
  input  logic                              cfg_wr_en,
  input  logic [nmf_pkg::CFG_W-1:0]         cfg_wr_data,
  input  nmf_pkg::nmf_cmd_t                 cmd,
  output nmf_pkg::nmf_sts_t                 sts,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [nmf_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast
);

  localparam int CFG_W       = nmf_pkg::CFG_W;
  localparam int POS_W       = $clog2(MAX_SIZE);
  localparam int POS_OUT_W   = nmf_pkg::POS_OUT_W;
  localparam int MEAN_W      = nmf_pkg::MEAN_W;
  localparam int COUNT_W     = nmf_pkg::COUNT_W;
  localparam int STEP_W      = nmf_pkg::DIV_STEPS;
  localparam int SUM_W       = VALUE_BITS + nmf_pkg::SUM_GROW;
  localparam int DIV_W       = SUM_W + FRAC_BITS;
  localparam int DIV_CYCLES  = (DIV_W + STEP_W - 1) / STEP_W;
  localparam int PAD_W       = DIV_CYCLES * STEP_W;
  localparam int QX_W        = (PAD_W > MEAN_W) ? PAD_W : MEAN_W;
  localparam int LINE_W      = 2 * VALUE_BITS;
  localparam logic [CFG_W-1:0] MAX_N = CFG_W'(MAX_SIZE);

  // Reciprocals of the neighbor counts, scaled by 2^RECIP_SHIFT and rounded up. Two
  // guard bits above the dividend width keep the truncated product exact.
  localparam int RECIP_SHIFT = DIV_W + 2;
  localparam int RECIP_W     = DIV_W + 1;
  localparam int PROD_W      = STEP_W + RECIP_W;
  localparam int ACC_W       = PAD_W + RECIP_W;
  localparam logic [63:0]        RECIP_ONE = 64'd1 << RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_3   = RECIP_W'((RECIP_ONE + 64'd2) / 64'd3);
  localparam logic [RECIP_W-1:0] RECIP_5   = RECIP_W'((RECIP_ONE + 64'd4) / 64'd5);
  localparam logic [RECIP_W-1:0] RECIP_8   = RECIP_W'(RECIP_ONE >> 3);

  // Configuration and position state.
  logic [CFG_W-1:0] size_r;
  logic [POS_W-1:0] last_idx;
  logic [POS_W-1:0] pos_row_r;
  logic [POS_W-1:0] pos_col_r;
  logic [POS_W-1:0] pos_row_nxt;
  logic [POS_W-1:0] pos_col_nxt;

  // Incoming word, line store and window.
  logic signed [VALUE_BITS-1:0] item_val_r;
  logic [LINE_W-1:0]            line_rd;
  logic signed [VALUE_BITS-1:0] line_top;
  logic signed [VALUE_BITS-1:0] line_mid;
  logic signed [VALUE_BITS-1:0] win_r [3][3];

  // Neighbor selection and sum.
  logic [POS_W-1:0]        cen_row;
  logic [POS_W-1:0]        cen_col;
  logic [2:0]              row_ok;
  logic [2:0]              col_ok;
  logic [1:0]              tap_row;
  logic [1:0]              tap_col;
  logic [8:0]              nb_mask;
  logic [COUNT_W-1:0]      nb_cnt;
  logic signed [SUM_W-1:0] nb_sum;
  logic [SUM_W-1:0]        sum_bits;
  logic [SUM_W-1:0]        sum_mag;

  // Divider.
  logic [PAD_W-1:0]   dvd_r;
  logic [PAD_W-1:0]   dvd_nxt;
  logic [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]   acc_nxt;
  logic [RECIP_W-1:0] recip_sel;
  logic [PROD_W-1:0]  part_prod;
  logic [COUNT_W-1:0] cnt_r;
  logic               neg_r;
  logic [POS_W-1:0]   res_row_r;
  logic [POS_W-1:0]   res_col_r;
  logic               res_done_r;
  logic [QX_W-1:0]    quo_ext;
  logic [QX_W-1:0]    mean_full;

  // Output register.
  logic                 out_valid_r;
  logic [POS_OUT_W-1:0] out_row_r;
  logic [POS_OUT_W-1:0] out_col_r;
  logic [MEAN_W-1:0]    out_mean_r;
  logic [COUNT_W-1:0]   out_cnt_r;
  logic                 out_last_r;

  // Sizes outside the legal range are clamped.
  always_comb begin
    if (size_r < 7'd2) begin
      last_idx = POS_W'(1);
    end else if (size_r > MAX_N) begin
      last_idx = POS_W'(MAX_SIZE - 1);
    end else begin
      last_idx = POS_W'(size_r - 7'd1);
    end
  end

  always_comb begin
    if (pos_col_r == last_idx) begin
      pos_col_nxt = '0;
      pos_row_nxt = (pos_row_r == last_idx) ? '0 : pos_row_r + 1'b1;
    end else begin
      pos_col_nxt = pos_col_r + 1'b1;
      pos_row_nxt = pos_row_r;
    end
  end

  // Each entry holds the column's values from the two rows above: {top, mid}.
  nmf_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_SIZE)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (cmd.load),
    .wr_addr (pos_col_r),
    .wr_data ({line_mid, item_val_r}),
    .rd_addr (pos_col_r),
    .rd_data (line_rd)
  );

  assign line_top = line_rd[LINE_W-1:VALUE_BITS];
  assign line_mid = line_rd[VALUE_BITS-1:0];

  // The result's center is one row and column behind the newest word unless the
  // selects point at the bottom row or the right column.
  assign cen_row = cmd.sel_row ? pos_row_r : pos_row_r - 1'b1;
  assign cen_col = cmd.sel_col ? pos_col_r : pos_col_r - 1'b1;

  assign row_ok = {cen_row != last_idx, 1'b1, cen_row != '0};
  assign col_ok = {cen_col != last_idx, 1'b1, cen_col != '0};

  // Taps that would fall past the newest row or column are always outside the
  // matrix, so clamping their index only avoids reading beyond the window.
  always_comb begin
    nb_sum  = '0;
    nb_mask = '0;
    tap_row = '0;
    tap_col = '0;
    for (int di = 0; di < 3; di++) begin
      for (int dj = 0; dj < 3; dj++) begin
        if (!(di == 1 && dj == 1)) begin
          tap_row = (di == 2) ? 2'd2 : 2'(di) + 2'(cmd.sel_row);
          tap_col = (dj == 2) ? 2'd2 : 2'(dj) + 2'(cmd.sel_col);
          if (row_ok[di] && col_ok[dj]) begin
            nb_mask[di * 3 + dj] = 1'b1;
            nb_sum = nb_sum + SUM_W'(win_r[tap_row][tap_col]);
          end
        end
      end
    end
  end

  assign nb_cnt   = COUNT_W'($countones(nb_mask));
  assign sum_bits = nb_sum;
  assign sum_mag  = sum_bits[SUM_W-1] ? (~sum_bits + 1'b1) : sum_bits;

  // Division by the neighbor count as a multiplication by its reciprocal. The
  // dividend enters eight bits a cycle, top digit first, and the quotient is the
  // product shifted down by RECIP_SHIFT.
  always_comb begin
    unique case (cnt_r)
      4'd3:    recip_sel = RECIP_3;
      4'd5:    recip_sel = RECIP_5;
      default: recip_sel = RECIP_8;
    endcase
  end

  assign part_prod = PROD_W'(dvd_r[PAD_W-1 -: STEP_W]) * PROD_W'(recip_sel);
  assign acc_nxt   = {acc_r[ACC_W-STEP_W-1:0], {STEP_W{1'b0}}} + ACC_W'(part_prod);
  assign dvd_nxt   = {dvd_r[PAD_W-STEP_W-1:0], {STEP_W{1'b0}}};

  assign quo_ext   = QX_W'(acc_r[ACC_W-1:RECIP_SHIFT]);
  assign mean_full = neg_r ? (~quo_ext + 1'b1) : quo_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= nmf_pkg::SIZE_RESET;
      pos_row_r   <= '0;
      pos_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        size_r    <= cfg_wr_data;
        pos_row_r <= '0;
        pos_col_r <= '0;
      end else if (cmd.advance) begin
        pos_row_r <= pos_row_nxt;
        pos_col_r <= pos_col_nxt;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_val_r <= in_value;
    end
    if (cmd.load) begin
      for (int x = 0; x < 3; x++) begin
        win_r[x][0] <= win_r[x][1];
        win_r[x][1] <= win_r[x][2];
      end
      win_r[0][2] <= line_top;
      win_r[1][2] <= line_mid;
      win_r[2][2] <= item_val_r;
    end
    if (cmd.sum) begin
      dvd_r      <= PAD_W'(sum_mag) << FRAC_BITS;
      acc_r      <= '0;
      cnt_r      <= nb_cnt;
      neg_r      <= sum_bits[SUM_W-1];
      res_row_r  <= cen_row;
      res_col_r  <= cen_col;
      res_done_r <= (cen_row == last_idx) && (cen_col == last_idx);
    end else if (cmd.div_step) begin
      dvd_r <= dvd_nxt;
      acc_r <= acc_nxt;
    end
    if (cmd.emit) begin
      out_row_r  <= POS_OUT_W'(res_row_r);
      out_col_r  <= POS_OUT_W'(res_col_r);
      out_mean_r <= mean_full[MEAN_W-1:0];
      out_cnt_r  <= cnt_r;
      out_last_r <= res_done_r;
    end
  end

  assign sts.has_results = (pos_row_r != '0) && (pos_col_r != '0);
  assign sts.last_row    = pos_row_r == last_idx;
  assign sts.last_col    = pos_col_r == last_idx;
  assign sts.out_free    = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_mean_r, out_col_r, out_row_r};
  assign out_tlast  = out_last_r;

  `NMF_ASSERT_NOW(a_count_legal, out_valid_r,
    out_cnt_r == 4'd3 || out_cnt_r == 4'd5 || out_cnt_r == 4'd8,
    "neighbor count is not three or five or eight")
  `NMF_ASSERT_NOW(a_done_on_corner, out_valid_r && out_last_r, out_row_r == out_col_r,
    "final-position flag set off the diagonal")
  `NMF_ASSERT_NOW(a_pos_in_range, 1'b1, pos_row_r <= last_idx && pos_col_r <= last_idx,
    "write position lies outside the matrix")

endmodule

### hdl/nmf_ctrl.sv
// Controller: sequences window load, per-result sum, division and output hand-off.
`include "neighbour_mean_filter_3x3_unit_macros.svh"
module nmf_ctrl #(
  parameter int VALUE_BITS = nmf_pkg::VALUE_BITS_DEF,
  parameter int FRAC_BITS  = nmf_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  nmf_pkg::nmf_sts_t sts,
  output nmf_pkg::nmf_cmd_t cmd
);

  localparam int DIV_W      = VALUE_BITS + nmf_pkg::SUM_GROW + FRAC_BITS;
  localparam int DIV_CYCLES = (DIV_W + nmf_pkg::DIV_STEPS - 1) / nmf_pkg::DIV_STEPS;
  localparam int DCNT_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_CYCLES - 1);

  nmf_pkg::nmf_state_t state_r;
  nmf_pkg::nmf_state_t state_nxt;
  logic                sel_row_r;
  logic                sel_row_nxt;
  logic                sel_col_r;
  logic                sel_col_nxt;
  logic [DCNT_W-1:0]   div_cnt_r;
  logic [DCNT_W-1:0]   div_cnt_nxt;
  logic                more;

  // Results of one word go out row by row, left column before right column.
  assign more = (!sel_col_r && sts.last_col) || (!sel_row_r && sts.last_row);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= nmf_pkg::ST_IDLE;
      sel_row_r <= 1'b0;
      sel_col_r <= 1'b0;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      sel_row_r <= sel_row_nxt;
      sel_col_r <= sel_col_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    sel_row_nxt = sel_row_r;
    sel_col_nxt = sel_col_r;
    div_cnt_nxt = div_cnt_r;
    unique case (state_r)
      nmf_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt   = nmf_pkg::ST_LOAD;
          sel_row_nxt = 1'b0;
          sel_col_nxt = 1'b0;
        end
      end
      nmf_pkg::ST_LOAD: begin
        state_nxt = sts.has_results ? nmf_pkg::ST_SUM : nmf_pkg::ST_IDLE;
      end
      nmf_pkg::ST_SUM: begin
        state_nxt   = nmf_pkg::ST_DIV;
        div_cnt_nxt = '0;
      end
      nmf_pkg::ST_DIV: begin
        if (div_cnt_r == DCNT_LAST) begin
          state_nxt = nmf_pkg::ST_EMIT;
        end else begin
          div_cnt_nxt = div_cnt_r + 1'b1;
        end
      end
      nmf_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          if (!sel_col_r && sts.last_col) begin
            sel_col_nxt = 1'b1;
            state_nxt   = nmf_pkg::ST_SUM;
          end else if (!sel_row_r && sts.last_row) begin
            sel_row_nxt = 1'b1;
            sel_col_nxt = 1'b0;
            state_nxt   = nmf_pkg::ST_SUM;
          end else begin
            state_nxt = nmf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = nmf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd         = '0;
    cmd.sel_row = sel_row_r;
    cmd.sel_col = sel_col_r;
    unique case (state_r)
      nmf_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      nmf_pkg::ST_LOAD: begin
        cmd.load    = 1'b1;
        cmd.advance = !sts.has_results;
      end
      nmf_pkg::ST_SUM: begin
        cmd.sum = 1'b1;
      end
      nmf_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      nmf_pkg::ST_EMIT: begin
        cmd.emit    = sts.out_free;
        cmd.advance = sts.out_free && !more;
      end
      default: begin
      end
    endcase
  end

  `NMF_ASSERT_NEXT(a_accept_loads, cmd.accept, state_r == nmf_pkg::ST_LOAD,
    "accepted word not followed by a window load")
  `NMF_ASSERT_NEXT(a_emit_continues, cmd.emit && !cmd.advance, state_r == nmf_pkg::ST_SUM,
    "pending result of the current word was skipped")
  `NMF_ASSERT_NOW(a_div_bound, state_r == nmf_pkg::ST_DIV, div_cnt_r <= DCNT_LAST,
    "divider ran past its last step")

endmodule

### hdl/neighbour_mean_filter_3x3_unit.sv
// Top level of the 3x3 neighbor mean filter. It takes an N by N matrix in raster
// order, one word per input transfer, and returns for each position the mean of its
// in-bounds neighbors (center excluded) as signed fixed point with FRAC_BITS fraction
// bits, truncated toward zero, together with the position and the neighbor count.
// A result leaves as soon as its last neighbor has arrived, so one input word yields
// zero to four results; tlast marks the result of the bottom-right position. Writing
// the size register restarts the matrix at the top-left position. A word that
// completes no neighborhood passes through accept with line store read, then window
// shift. Each result it completes then takes a window sum, the shared reciprocal
// multiplier taking eight dividend bits a cycle, and a load of the output register,
// which waits while the output is stalled. The next word is taken as soon as the
// previous word's last result sits in the output register. The line store needs no
// clearing after reset.
module neighbour_mean_filter_3x3_unit #(
  parameter int MAX_SIZE   = nmf_pkg::MAX_SIZE_DEF,
  parameter int VALUE_BITS = nmf_pkg::VALUE_BITS_DEF,
  parameter int FRAC_BITS  = nmf_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // element_value
  input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // result_row, result_col, mean_value, neighbour_count
  output logic [nmf_pkg::OUT_DATA_W-1:0]      out_tdata,
  // matrix_done
  output logic                                out_tlast,
  input  logic                                cfg_wr_en,
  input  logic [nmf_pkg::CFG_W-1:0]           cfg_wr_data
);

  nmf_pkg::nmf_cmd_t cmd;
  nmf_pkg::nmf_sts_t sts;

  nmf_ctrl #(
    .VALUE_BITS (VALUE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nmf_datapath #(
    .MAX_SIZE   (MAX_SIZE),
    .VALUE_BITS (VALUE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_value    (in_tdata[VALUE_BITS-1:0]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule
